// ----- sv/hhbv_pkg.sv -----
// ----------------------------------------------------------------------------
// hhbv_pkg
// Shared constants, per-line checker state and character class functions
// for the HTTP header block validator.
// ----------------------------------------------------------------------------
package hhbv_pkg;

  // Default saturation limit of the line counter
  localparam int unsigned MAX_LINES_DEFAULT = 255;

  // Width of the line counter carried on the result
  localparam int unsigned COUNT_W = 8;

  // Characters with a role in line framing
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_TAB   = 8'h09;

  // Per-line checker flags
  typedef struct packed {
    logic colon_seen;
    logic name_nonempty;
    logic line_bad;
  } line_st_t;

  localparam line_st_t LINE_CLEAR = '{colon_seen: 1'b0, name_nonempty: 1'b0,
                                      line_bad: 1'b0};

  // Printable ASCII range
  function automatic logic is_print(input logic [7:0] c);
    is_print = (c >= 8'h20) && (c <= 8'h7E);
  endfunction

  // Token separators, not allowed in a field name
  function automatic logic is_separator(input logic [7:0] c);
    is_separator = c inside {8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B,
                             8'h3A, 8'h5C, 8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F,
                             8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09};
  endfunction

  // Check one content byte of a line against name or value rules
  function automatic line_st_t take_content(input line_st_t st, input logic [7:0] c);
    line_st_t r;
    r = st;
    if (!st.colon_seen) begin
      if (c == CHAR_COLON) begin
        r.colon_seen = 1'b1;
        if (!st.name_nonempty) r.line_bad = 1'b1;
      end else begin
        r.name_nonempty = 1'b1;
        if (!is_print(c) || is_separator(c)) r.line_bad = 1'b1;
      end
    end else if (!is_print(c) && (c != CHAR_TAB)) begin
      r.line_bad = 1'b1;
    end
    take_content = r;
  endfunction

endpackage

// ----- sv/http_header_block_validator.sv -----
// ----------------------------------------------------------------------------
// http_header_block_validator
// Byte-wide checker of an HTTP/1.1 header block: one verdict per buffer.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one header byte per transaction in s_tdata[7:0];
//   s_tlast marks the final byte of a buffer, after which all line state
//   returns to the start of a new block.
//   Output stream (m_*): at most one result per buffer, given either at the
//   empty line that ends the block or with the buffer's last byte.
//   Bytes after the ending empty line are ignored until s_tlast.
//   A result is registered and presented in the cycle after the byte that causes it.
//   Throughput: one byte per cycle while the output slot is free; the
//   byte-to-byte dependency is a single phase/flag update plus a character class lookup, done combinationally.
//   The output register lets a new byte enter while a result waits, as long
//   as the slot is freed in the same cycle (s_tready = !m_tvalid | m_tready).
//   When the receiver stalls with a result held, input stalls only until
//   that result is taken; bytes that produce no result still need the slot
//   free, so the input waits for the held result.
//   Reset (rst, synchronous): clears the output slot and starts a new block.
// ----------------------------------------------------------------------------
module http_header_block_validator #(
  parameter int unsigned MAX_LINES = hhbv_pkg::MAX_LINES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [0] verdict, [1] blank_line_seen,
                                 // [9:2] line_count, [15:10] zero
);

  localparam int unsigned CountMax = (1 << hhbv_pkg::COUNT_W) - 1;
  localparam logic [hhbv_pkg::COUNT_W-1:0] CountCap =
    hhbv_pkg::COUNT_W'((MAX_LINES < CountMax) ? MAX_LINES : CountMax);

  typedef enum logic [1:0] {
    PH_START,
    PH_LINE,
    PH_DRAIN
  } phase_t;

  // Block state
  phase_t                        phase, phase_next;
  logic                          first_line, first_line_next;
  logic                          cr_pending, cr_pending_next;
  hhbv_pkg::line_st_t            line_st, line_st_next;
  logic                          block_bad, block_bad_next;
  logic [hhbv_pkg::COUNT_W-1:0]  lines_done, lines_done_next;

  // Result slot
  logic                          emit;
  logic                          res_verdict;
  logic                          res_blank;
  logic [hhbv_pkg::COUNT_W-1:0]  res_count;
  logic                          accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Next-state and result logic for one byte
  always_comb begin
    phase_next      = phase;
    first_line_next = first_line;
    cr_pending_next = cr_pending;
    line_st_next    = line_st;
    block_bad_next  = block_bad;
    lines_done_next = lines_done;
    emit            = 1'b0;
    res_verdict     = block_bad;
    res_blank       = 1'b1;
    res_count       = lines_done;

    case (phase)
      PH_START, PH_LINE: begin
        if (cr_pending && (s_tdata == hhbv_pkg::CHAR_LF)) begin
          cr_pending_next = 1'b0;
          if ((phase == PH_START) && !first_line) begin
            // empty line closes the block
            phase_next = PH_DRAIN;
            emit       = 1'b1;
          end else begin
            // complete line: fold its verdict into the block
            if (line_st.line_bad || !line_st.colon_seen) block_bad_next = 1'b1;
            if (lines_done < CountCap) lines_done_next = lines_done + 1'b1;
            first_line_next = 1'b0;
            line_st_next    = hhbv_pkg::LINE_CLEAR;
            phase_next      = PH_START;
          end
        end else begin
          // a CR not followed by LF counts as content
          if (cr_pending) begin
            line_st_next = hhbv_pkg::take_content(line_st_next, hhbv_pkg::CHAR_CR);
            phase_next   = PH_LINE;
          end
          if (s_tdata == hhbv_pkg::CHAR_CR) begin
            cr_pending_next = 1'b1;
          end else begin
            cr_pending_next = 1'b0;
            line_st_next    = hhbv_pkg::take_content(line_st_next, s_tdata);
            phase_next      = PH_LINE;
          end
        end
      end
      default: begin
        // draining until the buffer's last byte
      end
    endcase

    // end of buffer: report if not yet reported, then start over
    if (s_tlast) begin
      if (!emit && (phase_next != PH_DRAIN) && (phase != PH_DRAIN) &&
          (phase == PH_START || phase == PH_LINE)) begin
        emit        = 1'b1;
        res_blank   = 1'b0;
        res_verdict = block_bad_next;
        res_count   = lines_done_next;
      end
      phase_next      = PH_START;
      first_line_next = 1'b1;
      cr_pending_next = 1'b0;
      line_st_next    = hhbv_pkg::LINE_CLEAR;
      block_bad_next  = 1'b0;
      lines_done_next = '0;
    end
  end

  // State and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      first_line <= 1'b1;
      cr_pending <= 1'b0;
      line_st    <= hhbv_pkg::LINE_CLEAR;
      block_bad  <= 1'b0;
      lines_done <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (accept) begin
        phase      <= phase_next;
        first_line <= first_line_next;
        cr_pending <= cr_pending_next;
        line_st    <= line_st_next;
        block_bad  <= block_bad_next;
        lines_done <= lines_done_next;
      end
      if (accept && emit) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {6'b0, res_count, res_blank, res_verdict};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Checks
  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=>
      (phase == PH_START && first_line && lines_done == '0 && !block_bad))
    else $error("block state not restarted after last byte");

  a_count_capped: assert property (@(posedge clk) disable iff (rst)
    lines_done <= CountCap)
    else $error("line counter beyond its cap");

  a_drain_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == PH_DRAIN && !s_tlast) |=> !m_tvalid)
    else $error("result produced while draining");

endmodule
